>>> sv/vlcf_pkg.sv
// Shared types and codes for the voice link connection controller.
// No dependencies.
`timescale 1ns / 1ps

package vlcf_pkg;

  localparam int INDEX_BITS_DEF = 3;

  typedef enum logic [2:0] {
    ST_SHUTDOWN = 3'd0,
    ST_LISTEN   = 3'd1,
    ST_OPENING  = 3'd2,
    ST_OPEN_CL  = 3'd3,
    ST_OPEN     = 3'd4,
    ST_CLOSING  = 3'd5,
    ST_CLOSE_OP = 3'd6,
    ST_SHUTTING = 3'd7
  } link_state_t;

  typedef enum logic [2:0] {
    EV_LISTEN   = 3'd0,
    EV_OPEN     = 3'd1,
    EV_CLOSE    = 3'd2,
    EV_SHUTDOWN = 3'd3,
    EV_UP       = 3'd4,
    EV_DOWN     = 3'd5,
    EV_REQUEST  = 3'd6,
    EV_NONE     = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    CR_NONE   = 2'd0,
    CR_LISTEN = 2'd1,
    CR_ORIG   = 2'd2
  } create_t;

  typedef enum logic [2:0] {
    PS_CVSD_S3 = 3'd0,
    PS_CVSD_S4 = 3'd1,
    PS_MSBC_T2 = 3'd2,
    PS_LC3_T2  = 3'd3,
    PS_CVSD_D1 = 3'd4
  } param_set_t;

  // removal outcome
  localparam logic [1:0] RM_STARTED = 2'd0;
  localparam logic [1:0] RM_FREED   = 2'd1;

  // negotiated codec
  localparam logic [1:0] CODEC_MSBC = 2'd1;
  localparam logic [1:0] CODEC_LC3  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LOCAL_S4 = 2'd0;
  localparam logic [1:0] REG_PEER_S4  = 2'd1;
  localparam logic [1:0] REG_CODEC    = 2'd2;

endpackage

>>> sv/voice_link_connection_fsm_core.sv
// Voice link connection controller: event stream in, one result per event out.
// Depends on vlcf_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis carries one event per transfer: tuser holds the event code, tdata
//   the removal outcome, the link index for a create and the plain-SCO flag.
//   m_axis returns one result per event: new state, commands issued, link
//   settings, reject/claim flags and the held link index.
//   cfg writes one of three registers (local S4, peer S4, codec) and is always
//   ready; the user must write it only while no event is in flight (not enforced).
// The result of an event is registered and appears on m_axis in the cycle
//   after its transfer. Throughput: one event per cycle while m_axis takes
//   results; the whole transition is one lookup on the state register, so
//   nothing limits the rate beyond the single output register.
// Reset (rst, synchronous): state shutdown, no index held, registers zero,
//   output empty.
// Stall: while a result waits on m_axis, s_axis still takes an event in the
//   cycle the result is taken; otherwise s_axis_tready drops until it is.
//
module voice_link_connection_fsm_core
  import vlcf_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // remove_status[1:0], new_link_index, plain_sco_request, zero pad
  input  logic [((INDEX_BITS + 10) / 8) * 8 - 1:0] s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // link_state[2:0], create_cmd[1:0], remove_cmd, param_set[2:0],
  // request_rejected, claim_audio, index_valid, held_index, zero pad
  output logic [((INDEX_BITS + 19) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [1:0]            cfg_data
);

  localparam int OUT_W       = 12 + INDEX_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // configuration
  logic       local_s4;
  logic       peer_s4;
  logic [1:0] codec;

  // controller state
  link_state_t           state;
  logic                  index_held;
  logic [INDEX_BITS-1:0] link_index;

  // result register
  link_state_t           out_state;
  create_t               out_create;
  logic                  out_remove;
  param_set_t            out_param;
  logic                  out_rejected;
  logic                  out_claim;
  logic                  out_valid_idx;
  logic [INDEX_BITS-1:0] out_index;

  // input fields
  event_t                ev;
  logic [1:0]            rs;
  logic [INDEX_BITS-1:0] ni;
  logic                  plain;

  // next values
  link_state_t           state_next;
  logic                  held_next;
  logic [INDEX_BITS-1:0] index_next;
  create_t               create_next;
  logic                  remove_next;
  param_set_t            param_next;
  logic                  claim_next;
  logic                  rejected_next;
  logic                  do_rm;
  logic                  do_cr;
  logic                  orig;
  logic                  close_if_pending;
  logic                  pending;

  logic in_xfer;

  assign ev    = event_t'(s_axis_tuser);
  assign rs    = s_axis_tdata[1:0];
  assign ni    = s_axis_tdata[INDEX_BITS+1:2];
  assign plain = s_axis_tdata[INDEX_BITS+2];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_comb begin
    state_next       = state;
    held_next        = index_held;
    index_next       = link_index;
    create_next      = CR_NONE;
    remove_next      = 1'b0;
    param_next       = PS_CVSD_S3;
    claim_next       = 1'b0;
    rejected_next    = 1'b0;
    do_rm            = 1'b0;
    do_cr            = 1'b0;
    orig             = 1'b0;
    close_if_pending = 1'b0;
    pending          = 1'b0;

    if (ev == EV_REQUEST) begin
      if (state == ST_LISTEN) begin
        if (plain) param_next = PS_CVSD_D1;
        else if (codec == CODEC_LC3) param_next = PS_LC3_T2;
        else if (codec == CODEC_MSBC) param_next = PS_MSBC_T2;
        else if (local_s4) param_next = PS_CVSD_S4;
        else param_next = PS_CVSD_S3;
        claim_next = 1'b1;
      end else begin
        rejected_next = 1'b1;
      end
      state_next = ST_OPENING;
    end else if (!(ev == EV_CLOSE && !index_held)) begin
      // link down drops the index before the transition
      if (ev == EV_DOWN) begin
        held_next  = 1'b0;
        index_next = '0;
      end
      case (state)
        ST_SHUTDOWN, ST_LISTEN: begin
          if (ev == EV_LISTEN) begin
            do_cr      = 1'b1;
            state_next = ST_LISTEN;
          end else if (ev == EV_OPEN) begin
            do_rm      = 1'b1;
            do_cr      = 1'b1;
            orig       = 1'b1;
            state_next = ST_OPENING;
          end else if (state == ST_LISTEN && ev == EV_SHUTDOWN) begin
            do_rm      = 1'b1;
            state_next = ST_SHUTDOWN;
          end else if (state == ST_LISTEN && ev == EV_DOWN) begin
            do_cr = 1'b1;
          end
        end
        ST_OPENING: begin
          if (ev == EV_CLOSE) state_next = ST_OPEN_CL;
          else if (ev == EV_SHUTDOWN) state_next = ST_SHUTTING;
          else if (ev == EV_UP) state_next = ST_OPEN;
          else if (ev == EV_DOWN) begin
            do_cr      = 1'b1;
            state_next = ST_LISTEN;
          end
        end
        ST_OPEN_CL: begin
          if (ev == EV_OPEN) state_next = ST_OPENING;
          else if (ev == EV_SHUTDOWN) state_next = ST_SHUTTING;
          else if (ev == EV_UP) begin
            do_rm      = 1'b1;
            state_next = ST_CLOSING;
          end else if (ev == EV_DOWN) state_next = ST_LISTEN;
        end
        ST_OPEN: begin
          if (ev == EV_CLOSE) begin
            do_rm            = 1'b1;
            close_if_pending = 1'b1;
          end else if (ev == EV_SHUTDOWN) begin
            do_rm      = 1'b1;
            state_next = ST_SHUTTING;
          end else if (ev == EV_DOWN) begin
            do_cr      = 1'b1;
            state_next = ST_LISTEN;
          end
        end
        ST_CLOSING: begin
          if (ev == EV_OPEN) state_next = ST_CLOSE_OP;
          else if (ev == EV_SHUTDOWN) state_next = ST_SHUTTING;
          else if (ev == EV_DOWN) begin
            do_cr      = 1'b1;
            state_next = ST_LISTEN;
          end
        end
        ST_CLOSE_OP: begin
          if (ev == EV_CLOSE) state_next = ST_CLOSING;
          else if (ev == EV_SHUTDOWN) state_next = ST_SHUTTING;
          else if (ev == EV_DOWN) begin
            do_cr      = 1'b1;
            orig       = 1'b1;
            state_next = ST_OPENING;
          end
        end
        default: begin  // shutting
          if (ev == EV_UP) do_rm = 1'b1;
          else if (ev == EV_DOWN || ev == EV_SHUTDOWN) state_next = ST_SHUTDOWN;
        end
      endcase

      // removal first: it may free the index for a create in the same event
      if (do_rm && held_next) begin
        remove_next = 1'b1;
        if (rs == RM_STARTED) begin
          pending = 1'b1;
        end else if (rs == RM_FREED) begin
          held_next  = 1'b0;
          index_next = '0;
        end
      end
      if (close_if_pending && pending) state_next = ST_CLOSING;

      if (do_cr && !held_next) begin
        create_next = orig ? CR_ORIG : CR_LISTEN;
        param_next  = (local_s4 && peer_s4) ? PS_CVSD_S4 : PS_CVSD_S3;
        claim_next  = orig;
        held_next   = 1'b1;
        index_next  = ni;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_s4 <= 1'b0;
      peer_s4  <= 1'b0;
      codec    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCAL_S4: local_s4 <= cfg_data[0];
        REG_PEER_S4:  peer_s4  <= cfg_data[0];
        REG_CODEC:    codec    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SHUTDOWN;
      index_held    <= 1'b0;
      link_index    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_xfer) begin
        state      <= state_next;
        index_held <= held_next;
        link_index <= index_next;
      end
      if (in_xfer) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_state     <= state_next;
      out_create    <= create_next;
      out_remove    <= remove_next;
      out_param     <= param_next;
      out_rejected  <= rejected_next;
      out_claim     <= claim_next;
      out_valid_idx <= held_next;
      out_index     <= index_next;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({out_index, out_valid_idx, out_claim, out_rejected,
                                      out_param, out_remove, out_create, out_state});

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_axis_tvalid)
    else $error("accepted event produced no result");

  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_state == state)
    else $error("shown state differs from state register");

  a_free_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_valid_idx) |-> out_index == '0)
    else $error("index reported while none held");

  a_create_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_create != CR_NONE) |-> out_valid_idx)
    else $error("create issued without holding an index");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_rejected) |->
      (out_state == ST_OPENING && !out_claim && out_param == PS_CVSD_S3))
    else $error("rejected request with wrong outcome");

endmodule
